### rtl/kads_pkg.sv
package kads_pkg;

    localparam int TIME_W     = 32;
    localparam int ANGLE_W    = 9;
    localparam int PI_W       = 10;
    localparam int GAP_W      = 14;
    localparam int DPS_W      = 9;
    localparam int LIM_W      = 10;
    localparam int ACC_W      = 11;
    localparam int MAG_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 16;

    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam status_t ST_THROTTLED = 2'd0;
    localparam status_t ST_READ_FAIL = 2'd1;
    localparam status_t ST_BASELINED = 2'd2;
    localparam status_t ST_TRACKED   = 2'd3;

    localparam cfg_idx_t REG_POLL_INTERVAL = 3'd0;
    localparam cfg_idx_t REG_MAX_GAP       = 3'd1;
    localparam cfg_idx_t REG_DEG_PER_STEP  = 3'd2;
    localparam cfg_idx_t REG_ACCUM_LIMIT   = 3'd3;
    localparam cfg_idx_t REG_INVERT        = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/kads_div.sv
// Restoring divider, one quotient bit per cycle.
module kads_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kads_pkg::MAG_W-1:0]   dividend,
    input  logic [kads_pkg::DPS_W-1:0]   divisor,
    output logic [kads_pkg::MAG_W-1:0]   quotient,
    output logic [kads_pkg::DPS_W-1:0]   remainder,
    output kads_pkg::div_stat_t          stat
);
    import kads_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic [MAG_W-1:0] quo_reg;
    logic [DPS_W-1:0] rem_reg;
    logic [DPS_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DPS_W:0]   trial;
    logic [DPS_W:0]   trial_diff;
    logic             fits;
    logic [DPS_W-1:0] rem_next;

    assign trial      = {rem_reg, quo_reg[MAG_W-1]};
    assign fits       = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};
    // partial remainder stays below the divisor, so the top bit drops
    assign rem_next   = fits ? trial_diff[DPS_W-1:0] : trial[DPS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/knob_angle_to_detent_steps_core.sv
// Throttled, failed and baselining polls go from the check straight to the output load;
// tracked polls pass through check, clamp, divide, sign fix and output load.
// One poll at a time: the next input transfer waits until the poll is back in S_IDLE,
// and longer while a stalled result holds the output register.
// Reset (rst_n, async, active low): control and configuration registers return to their
// defaults, tracking off, accumulator and timestamps cleared; payload is not reset.
module knob_angle_to_detent_steps_core #(
    parameter int CIRCLE_COUNTS = 360
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kads_pkg::IN_DATA_W-1:0]     s_tdata,   // time_ms[31:0], angle[40:32]
    input  logic [kads_pkg::IN_USER_W-1:0]     s_tuser,   // read_ok[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kads_pkg::OUT_DATA_W-1:0]    m_tdata,   // steps[10:0]
    output logic [kads_pkg::STATUS_W-1:0]      m_tuser,   // status[1:0]
    input  logic                               cfg_we,
    input  logic [kads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kads_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kads_pkg::*;

    localparam int CB = $clog2(CIRCLE_COUNTS + 1);
    localparam int DW = ((CB > ANGLE_W) ? CB : ANGLE_W) + 2;
    localparam int SW = ((DW > ACC_W) ? DW : ACC_W) + 1;
    localparam logic signed [DW-1:0] HALF_S = DW'(CIRCLE_COUNTS / 2);
    localparam logic signed [DW-1:0] CIRC_S = DW'(CIRCLE_COUNTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;

    logic [PI_W-1:0]  poll_interval_reg;
    logic [GAP_W-1:0] max_gap_reg;
    logic [DPS_W-1:0] dps_reg;
    logic [LIM_W-1:0] limit_reg;
    logic             invert_reg;

    logic                    tracking_reg;
    logic [ANGLE_W-1:0]      prev_angle_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [TIME_W-1:0]       last_poll_reg;
    logic [TIME_W-1:0]       last_good_reg;

    logic [TIME_W-1:0]      time_reg;
    logic [ANGLE_W-1:0]     angle_reg;
    logic                   ok_reg;
    logic signed [DW-1:0]   delta_reg;
    logic                   neg_reg;
    logic [ACC_W-1:0]       res_steps_reg;
    status_t                res_status_reg;
    logic                   m_tvalid_reg;
    logic [ACC_W-1:0]       m_steps_reg;
    status_t                m_status_reg;

    logic [TIME_W-1:0]       poll_diff;
    logic [TIME_W-1:0]       good_diff;
    logic                    throttled;
    logic                    gap;
    logic signed [DW-1:0]    diff_raw;
    logic signed [DW-1:0]    diff_wrap;
    logic signed [DW-1:0]    delta_dir;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    lim_s;
    logic signed [ACC_W-1:0] clamped;
    logic [ACC_W-1:0]        clamped_abs;
    logic [DPS_W-1:0]        dps_eff;
    logic [MAG_W-1:0]        quotient;
    logic [DPS_W-1:0]        remainder;
    div_stat_t               div_stat;
    logic [ACC_W-1:0]        q_ext;
    logic [ACC_W-1:0]        r_ext;

    assign poll_diff = time_reg - last_poll_reg;
    assign good_diff = time_reg - last_good_reg;
    assign throttled = poll_diff < TIME_W'(poll_interval_reg);
    assign gap       = good_diff > TIME_W'(max_gap_reg);

    assign diff_raw = DW'($signed({1'b0, angle_reg})) - DW'($signed({1'b0, prev_angle_reg}));

    always_comb
    begin
        if (diff_raw > HALF_S)
            diff_wrap = diff_raw - CIRC_S;
        else if (diff_raw < -HALF_S)
            diff_wrap = diff_raw + CIRC_S;
        else
            diff_wrap = diff_raw;
    end

    assign delta_dir = invert_reg ? -diff_wrap : diff_wrap;

    assign sum   = SW'(acc_reg) + SW'(delta_reg);
    assign lim_s = SW'($signed({1'b0, limit_reg}));

    always_comb
    begin
        if (sum > lim_s)
            clamped = ACC_W'(lim_s);
        else if (sum < -lim_s)
            clamped = ACC_W'(-lim_s);
        else
            clamped = ACC_W'(sum);
    end

    assign clamped_abs = clamped[ACC_W-1] ? ACC_W'(-clamped) : ACC_W'(clamped);
    assign dps_eff     = (dps_reg == '0) ? DPS_W'(1) : dps_reg;

    kads_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_ACC),
        .dividend  (clamped_abs[MAG_W-1:0]),
        .divisor   (dps_eff),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    assign q_ext = ACC_W'(quotient);
    assign r_ext = ACC_W'(remainder);

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            poll_interval_reg <= PI_W'(10);
            max_gap_reg       <= GAP_W'(30);
            dps_reg           <= DPS_W'(30);
            limit_reg         <= LIM_W'(90);
            invert_reg        <= 1'b0;
            tracking_reg      <= 1'b0;
            prev_angle_reg    <= '0;
            acc_reg           <= '0;
            last_poll_reg     <= '0;
            last_good_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLL_INTERVAL: poll_interval_reg <= cfg_data[PI_W-1:0];
                    REG_MAX_GAP:       max_gap_reg       <= cfg_data[GAP_W-1:0];
                    REG_DEG_PER_STEP:  dps_reg           <= cfg_data[DPS_W-1:0];
                    REG_ACCUM_LIMIT:   limit_reg         <= cfg_data[LIM_W-1:0];
                    REG_INVERT:        invert_reg        <= cfg_data[0];
                    default: ;
                endcase
            end

            // output register: load in S_DONE once free, drop after its transfer
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (throttled)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        last_poll_reg <= time_reg;
                        if (!ok_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            prev_angle_reg <= angle_reg;
                            last_good_reg  <= time_reg;
                            tracking_reg   <= 1'b1;
                            if (gap)
                                acc_reg <= '0;
                            if (gap || !tracking_reg)
                                state_reg <= S_DONE;
                            else
                                state_reg <= S_ACC;
                        end
                    end
                end
                S_ACC:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        // remainder keeps the sign of the clamped accumulator
                        acc_reg   <= neg_reg ? $signed(-r_ext) : $signed(r_ext);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    time_reg  <= s_tdata[TIME_W-1:0];
                    angle_reg <= s_tdata[TIME_W+ANGLE_W-1:TIME_W];
                    ok_reg    <= s_tuser[0];
                end
            end
            S_CHECK:
            begin
                delta_reg     <= delta_dir;
                res_steps_reg <= '0;
                if (throttled)
                    res_status_reg <= ST_THROTTLED;
                else if (!ok_reg)
                    res_status_reg <= ST_READ_FAIL;
                else if (gap || !tracking_reg)
                    res_status_reg <= ST_BASELINED;
                else
                    res_status_reg <= ST_TRACKED;
            end
            S_ACC:
            begin
                neg_reg <= clamped[ACC_W-1];
            end
            S_DIV:
            begin
                if (div_stat.done)
                    res_steps_reg <= neg_reg ? -q_ext : q_ext;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_steps_reg  <= res_steps_reg;
                    m_status_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(m_steps_reg);
    assign m_tuser  = m_status_reg;

endmodule

### rtl/kads_checker.sv
module kads_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [kads_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [kads_pkg::STATUS_W-1:0]      m_tuser
);
    import kads_pkg::*;

    // only tracked polls carry steps
    a_steps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_TRACKED) |-> m_tdata[ACC_W-1:0] == '0)
        else $error("nonzero steps on untracked result");

    // one poll at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a poll is in work");

    // a result never appears in the cycle right after its input transfer
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind knob_angle_to_detent_steps_core kads_checker u_kads_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
